### src/ptq_pkg.sv
// Package for the priority ticket queue: sizes, operation and status codes,
// and the structs passed along the cell chain. No dependencies.
package ptq_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 32;
  localparam int PRIO_W      = 2;
  localparam int ARR_W       = 32;
  localparam int OCC_W       = 5;
  localparam int STATUS_W    = 3;

  localparam logic [PRIO_W-1:0] PRIO_INSERT = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_NONE   = PRIO_W'(0);

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_SET_PRIO = 2'd1,
    OP_POP      = 2'd2,
    OP_FIND     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_FULL         = 3'd4,
    ST_BAD_PRIORITY = 3'd5
  } status_t;

  // Request broadcast to every cell while a scan runs.
  typedef struct packed {
    logic            pop;
    logic [ID_W-1:0] id;
  } ptq_req_t;

  // Record handed from cell to cell: the selected ticket and the first free slot.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrival;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
  } ptq_carry_t;

  // Update broadcast to the cells when an operation completes.
  typedef struct packed {
    logic              insert;
    logic              set_prio;
    logic              clear;
    logic [IDX_W-1:0]  slot;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrival;
  } ptq_wr_t;

endpackage

### src/ptq_cell.sv
// One slot of the ticket table plus its stage of the scan chain.
// Depends on ptq_pkg.
module ptq_cell
  import ptq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  ptq_req_t         req,
  input  ptq_wr_t          wr,
  input  ptq_carry_t       carry_in,
  output ptq_carry_t       carry_out
);

  logic              valid;
  logic [ID_W-1:0]   entry_id;
  logic [PRIO_W-1:0] entry_prio;
  logic [ARR_W-1:0]  entry_arrival;
  ptq_carry_t        carry_next;
  logic              match;
  logic              better;
  logic              take;
  logic              take_free;
  logic              wr_here;

  assign wr_here = (wr.slot == cell_index);

  always_comb begin
    match  = valid && (entry_id == req.id);
    // Strict compare keeps the lower slot on a full tie.
    better = !carry_in.hit || (entry_prio > carry_in.prio) ||
             ((entry_prio == carry_in.prio) && (entry_arrival < carry_in.arrival));
    take      = req.pop ? (valid && better) : (match && !carry_in.hit);
    take_free = !valid && !carry_in.free;

    carry_next = carry_in;
    if (take) begin
      carry_next.hit     = 1'b1;
      carry_next.hit_idx = cell_index;
      carry_next.id      = entry_id;
      carry_next.prio    = entry_prio;
      carry_next.arrival = entry_arrival;
    end
    if (take_free) begin
      carry_next.free     = 1'b1;
      carry_next.free_idx = cell_index;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here && wr.insert) begin
      valid <= 1'b1;
    end else if (wr_here && wr.clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here && wr.insert) begin
      entry_id      <= wr.id;
      entry_prio    <= PRIO_INSERT;
      entry_arrival <= wr.arrival;
    end else if (wr_here && wr.set_prio) begin
      entry_prio <= wr.prio;
    end
  end

endmodule

### src/priority_ticket_queue.sv
// Priority ticket queue: a chain of MAX_ENTRIES slot cells scanned per item.
// The item is latched in IDLE, the scan runs in SCAN, and the result is registered in FINISH.
// Takes one item at a time: a new item is accepted only back in IDLE, after the scan wave
// has crossed the cell chain one cell per cycle and the result has been issued.
// Reset: synchronous, active high; empties the table, zeroes arrival counter.
// Depends on ptq_pkg and ptq_cell.
module priority_ticket_queue
  import ptq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [ID_W-1:0]     ticket_id,
  input  logic [PRIO_W-1:0]   new_priority,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     out_id,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [ARR_W-1:0]    out_arrival,
  output logic [OCC_W-1:0]    occupancy
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t            state;
  op_t               req_op;
  logic [ID_W-1:0]   req_id;
  logic [PRIO_W-1:0] req_prio;
  logic [IDX_W-1:0]  scan_cnt;
  logic [ARR_W-1:0]  arrival_counter;
  logic [CNT_W-1:0]  ticket_count;

  ptq_req_t   req;
  ptq_wr_t    wr;
  ptq_carry_t chain_in  [MAX_ENTRIES];
  ptq_carry_t chain_out [MAX_ENTRIES];
  ptq_carry_t result;

  logic              fire;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic [ARR_W-1:0]  res_arrival;
  logic [CNT_W-1:0]  count_next;
  logic [ARR_W-1:0]  arrival_next;

  assign req.pop  = (req_op == OP_POP);
  assign req.id   = req_id;
  assign result   = chain_out[MAX_ENTRIES-1];
  assign in_ready = (state == IDLE);
  assign fire     = (state == FINISH) && (!out_valid || out_ready);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = '0;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    ptq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .req        (req),
      .wr         (wr),
      .carry_in   (chain_in[i]),
      .carry_out  (chain_out[i])
    );
  end

  // Resolve the operation from the record at the end of the chain.
  always_comb begin
    res_status   = ST_OK;
    res_id       = '0;
    res_prio     = PRIO_NONE;
    res_arrival  = '0;
    count_next   = ticket_count;
    arrival_next = arrival_counter;
    wr           = '0;
    wr.id        = req_id;
    wr.prio      = req_prio;
    wr.arrival   = arrival_counter;
    unique case (req_op)
      OP_INSERT: begin
        if (result.hit) begin
          res_status = ST_DUPLICATE;
        end else if (!result.free) begin
          res_status = ST_FULL;
        end else begin
          wr.insert    = fire;
          wr.slot      = result.free_idx;
          count_next   = ticket_count + CNT_W'(1);
          arrival_next = arrival_counter + ARR_W'(1);
        end
      end
      OP_SET_PRIO: begin
        if (req_prio == PRIO_NONE) begin
          res_status = ST_BAD_PRIORITY;
        end else if (!result.hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          wr.set_prio = fire;
          wr.slot     = result.hit_idx;
        end
      end
      OP_POP: begin
        if (!result.hit) begin
          res_status = ST_EMPTY;
        end else begin
          res_id      = result.id;
          res_prio    = result.prio;
          res_arrival = result.arrival;
          wr.clear    = fire;
          wr.slot     = result.hit_idx;
          count_next  = ticket_count - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (!result.hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_id      = result.id;
          res_prio    = result.prio;
          res_arrival = result.arrival;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      scan_cnt        <= '0;
      arrival_counter <= '0;
      ticket_count    <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Drop the item once taken, unless a new one replaces it this cycle
      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            req_op   <= op_t'(operation);
            req_id   <= ticket_id;
            req_prio <= new_priority;
            scan_cnt <= '0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          // Hold until the wave has passed the last cell.
          if (scan_cnt == IDX_W'(MAX_ENTRIES - 1)) begin
            state <= FINISH;
          end
          scan_cnt <= scan_cnt + IDX_W'(1);
        end
        FINISH: begin
          if (fire) begin
            ticket_count    <= count_next;
            arrival_counter <= arrival_next;
            out_valid       <= 1'b1;
            status          <= res_status;
            out_id          <= res_id;
            out_priority    <= res_prio;
            out_arrival     <= res_arrival;
            occupancy       <= OCC_W'(count_next);
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
